// ===== design/elt_pkg.sv =====
// Shared types and constants for the edge list table.
// Holds the payload structs, result codes and controller/datapath command bundles.
// No dependencies.
package elt_pkg;

  // Field widths fixed by the channel format
  localparam int unsigned VERTEX_BITS   = 16;
  localparam int unsigned WEIGHT_BITS   = 32;
  localparam int unsigned MODE_BITS     = 2;
  localparam int unsigned STATUS_BITS   = 3;
  localparam int unsigned OUT_IDX_BITS  = 7;
  localparam int unsigned OUT_CNT_BITS  = 8;

  // Default table depth
  localparam int unsigned MAX_EDGES_DEF = 128;

  // Operation codes (unused code 3 behaves as lookup)
  localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] STAT_INSERTED  = 3'd0;
  localparam logic [STATUS_BITS-1:0] STAT_PRESENT   = 3'd1;
  localparam logic [STATUS_BITS-1:0] STAT_DELETED   = 3'd2;
  localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [STATUS_BITS-1:0] STAT_FULL      = 3'd4;

  typedef struct packed {
    logic [MODE_BITS-1:0]          mode;
    logic [VERTEX_BITS-1:0]        src_vertex;
    logic [VERTEX_BITS-1:0]        dest_vertex;
    logic signed [WEIGHT_BITS-1:0] edge_weight;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]  status;
    logic [OUT_IDX_BITS-1:0] match_index;
    logic                    found;
    logic [OUT_CNT_BITS-1:0] count_after;
  } out_item_t;

  // One stored edge
  typedef struct packed {
    logic [VERTEX_BITS-1:0] src;
    logic [VERTEX_BITS-1:0] dest;
    logic [WEIGHT_BITS-1:0] weight;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic                   load_req;
    logic                   scan;
    logic                   insert;
    logic                   rd_last;
    logic                   move;
    logic                   load_out;
    logic [STATUS_BITS-1:0] code;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic                 scan_done;
    logic                 hit;
    logic                 full;
    logic                 out_busy;
    logic [MODE_BITS-1:0] mode;
  } sts_t;

endpackage

// ===== design/elt_ctrl.sv =====
// Sequencer for the edge list table: accept, scan, update, report.
// Depends on elt_pkg for command/status bundles and codes.
module elt_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         busy_o,
  input  elt_pkg::sts_t sts_i,
  output elt_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT,
    S_RDLAST,
    S_MOVE,
    S_FINISH
  } state_e;

  state_e                             state_q, state_d;
  logic [elt_pkg::STATUS_BITS-1:0]    code_q, code_d;

  assign busy_o = (state_q != S_IDLE);

  // Next state, result code and datapath commands
  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    cmd_o   = '0;
    cmd_o.code = code_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          case (sts_i.mode)
            elt_pkg::MODE_INSERT: begin
              if (sts_i.hit) begin
                code_d  = elt_pkg::STAT_PRESENT;
                state_d = S_FINISH;
              end else if (sts_i.full) begin
                code_d  = elt_pkg::STAT_FULL;
                state_d = S_FINISH;
              end else begin
                code_d  = elt_pkg::STAT_INSERTED;
                state_d = S_INSERT;
              end
            end
            elt_pkg::MODE_DELETE: begin
              if (sts_i.hit) begin
                code_d  = elt_pkg::STAT_DELETED;
                state_d = S_RDLAST;
              end else begin
                code_d  = elt_pkg::STAT_NOT_FOUND;
                state_d = S_FINISH;
              end
            end
            default: begin
              code_d  = sts_i.hit ? elt_pkg::STAT_PRESENT : elt_pkg::STAT_NOT_FOUND;
              state_d = S_FINISH;
            end
          endcase
        end
      end
      S_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = S_FINISH;
      end
      S_RDLAST: begin
        cmd_o.rd_last = 1'b1;
        state_d       = S_MOVE;
      end
      S_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = S_FINISH;
      end
      S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= elt_pkg::STAT_INSERTED;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

endmodule

// ===== design/elt_dp.sv =====
// Datapath of the edge list table: edge memory, count, scan pipeline, result register.
// Depends on elt_pkg; driven by elt_ctrl commands.
module elt_dp #(
  parameter int unsigned MaxEdges = elt_pkg::MAX_EDGES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  elt_pkg::in_item_t in_data_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output elt_pkg::out_item_t out_data_o,
  input  elt_pkg::cmd_t     cmd_i,
  output elt_pkg::sts_t     sts_o
);

  localparam int unsigned IdxW = $clog2(MaxEdges);
  localparam int unsigned CntW = $clog2(MaxEdges + 1);

  // Edge memory, no reset: entries are read only below the count
  elt_pkg::entry_t mem_q [MaxEdges];

  elt_pkg::in_item_t  req_q;
  elt_pkg::entry_t    rd_data_q;
  elt_pkg::out_item_t out_q;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    scan_q, scan_d;
  logic [IdxW-1:0]    rd_idx_q;
  logic [IdxW-1:0]    slot_q;
  logic [IdxW-1:0]    rd_addr;
  logic               rd_vld_q, rd_vld_d;
  logic               hit_q, hit_d;
  logic               out_valid_q;
  logic               match;
  logic               issue;
  logic               full;
  elt_pkg::entry_t    wr_data;
  logic [IdxW-1:0]    wr_addr;
  logic               wr_en;

  assign full  = (count_q == CntW'(MaxEdges));
  assign match = rd_vld_q && (rd_data_q.src == req_q.src_vertex)
               && (rd_data_q.dest == req_q.dest_vertex);

  // Scan issues one read per cycle until a hit or the end of the valid entries
  assign issue = cmd_i.scan && !hit_q && !match && (scan_q < count_q);

  always_comb begin
    scan_d   = scan_q;
    rd_vld_d = 1'b0;
    hit_d    = hit_q;
    if (cmd_i.load_req) begin
      scan_d = '0;
      hit_d  = 1'b0;
    end else begin
      if (issue) begin
        scan_d   = scan_q + CntW'(1);
        rd_vld_d = 1'b1;
      end
      if (cmd_i.scan && match) begin
        hit_d = 1'b1;
      end
    end
  end

  // Read address: scan pointer or last valid entry
  assign rd_addr = cmd_i.rd_last ? IdxW'(count_q - CntW'(1)) : scan_q[IdxW-1:0];

  // Write port: append on insert, move last into freed slot on delete
  always_comb begin
    wr_en   = cmd_i.insert || cmd_i.move;
    wr_addr = cmd_i.move ? slot_q : count_q[IdxW-1:0];
    wr_data = rd_data_q;
    if (cmd_i.insert) begin
      wr_data.src    = req_q.src_vertex;
      wr_data.dest   = req_q.dest_vertex;
      wr_data.weight = req_q.edge_weight;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.move) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    rd_idx_q <= scan_q[IdxW-1:0];
    if (cmd_i.scan && match && !hit_q) begin
      slot_q <= rd_idx_q;
    end
    if (cmd_i.load_out) begin
      out_q.status      <= cmd_i.code;
      out_q.found       <= hit_q;
      out_q.match_index <= hit_q ? elt_pkg::OUT_IDX_BITS'(slot_q) : '0;
      out_q.count_after <= elt_pkg::OUT_CNT_BITS'(count_q);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      scan_q   <= scan_d;
      rd_vld_q <= rd_vld_d;
      hit_q    <= hit_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.scan_done = hit_q || (!rd_vld_q && (scan_q >= count_q));
  assign sts_o.hit       = hit_q;
  assign sts_o.full      = full;
  assign sts_o.out_busy  = out_valid_q && out_stall_i;
  assign sts_o.mode      = req_q.mode;

  // Count stays within the table
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEdges))
    else $error("edge count beyond table depth");

  // Append only into a table that has room and lacks the pair
  a_insert_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> (!full && !hit_q))
    else $error("insert into full table or of present edge");

  // Move only after a successful search
  a_move_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.move |-> (hit_q && (count_q != '0)))
    else $error("move without a matching entry");

  // Loading a result always presents it next cycle
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("result loaded but not presented");

endmodule

// ===== design/edge_list_table_core.sv =====
// Edge list table top level: sequencer plus datapath.
// Depends on elt_pkg, elt_ctrl and elt_dp.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | elt_pkg::in_item_t
//   out     | output    | out_valid_o/out_stall_i | elt_pkg::out_item_t
//
// An operation is accept, a linear search that reads one stored edge per cycle
// through the single memory read port, draining of the compare, then an append
// or a delete move (read last, write), and finally the result load.
// Reset clears the edge count and all control; the memory is not cleared.
// A new item is taken while a finished result still waits in the output register;
// only the final result load waits on out_stall_i.
module edge_list_table_core #(
  parameter int unsigned MaxEdges = elt_pkg::MAX_EDGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  elt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output elt_pkg::out_item_t out_data_o
);

  elt_pkg::cmd_t cmd;
  elt_pkg::sts_t sts;
  logic          busy;

  assign in_stall_o = busy;

  elt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .busy_o     (busy),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  elt_dp #(
    .MaxEdges (MaxEdges)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== tb/sv/edge_list_table_core_test.sv =====
// Self-checking testbench for edge_list_table_core: directed and random edge operations.
// A scoreboard class predicts each result, and tasks drive the valid/stall channels.
// Depends on elt_pkg and the edge_list_table_core RTL.
module edge_list_table_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = elt_pkg::MAX_EDGES_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 2 * TABLE_DEPTH + 10;
  // Unused operation code, handled by the block as a lookup
  localparam logic [elt_pkg::MODE_BITS-1:0] MODE_SPARE = 2'd3;

  // Edge table mirror and the queue of results still to come
  class edge_scoreboard;
    logic [elt_pkg::VERTEX_BITS-1:0] src_tab[TABLE_DEPTH];
    logic [elt_pkg::VERTEX_BITS-1:0] dest_tab[TABLE_DEPTH];
    logic [elt_pkg::WEIGHT_BITS-1:0] weight_tab[TABLE_DEPTH];
    int unsigned edge_count = 0;
    elt_pkg::out_item_t pending_results[$];
    int unsigned err_count = 0;

    // First valid slot holding (s, d), or -1
    function int find_slot(logic [elt_pkg::VERTEX_BITS-1:0] s,
                           logic [elt_pkg::VERTEX_BITS-1:0] d);
      for (int i = 0; i < int'(edge_count); i++) begin
        if (src_tab[i] == s && dest_tab[i] == d) return i;
      end
      return -1;
    endfunction

    // Apply one accepted transfer to the mirror and queue its result
    function void note_input(elt_pkg::in_item_t op);
      int slot;
      int unsigned last;
      elt_pkg::out_item_t want;
      slot = find_slot(op.src_vertex, op.dest_vertex);
      want = '0;
      want.found = (slot >= 0);
      if (slot >= 0) want.match_index = elt_pkg::OUT_IDX_BITS'(slot);
      case (op.mode)
        elt_pkg::MODE_INSERT: begin
          if (slot >= 0) begin
            want.status = elt_pkg::STAT_PRESENT;
          end else if (edge_count >= TABLE_DEPTH) begin
            want.status = elt_pkg::STAT_FULL;
          end else begin
            src_tab[edge_count] = op.src_vertex;
            dest_tab[edge_count] = op.dest_vertex;
            weight_tab[edge_count] = op.edge_weight;
            edge_count++;
            want.status = elt_pkg::STAT_INSERTED;
          end
        end
        elt_pkg::MODE_DELETE: begin
          if (slot >= 0) begin
            // last entry fills the hole
            last = edge_count - 1;
            src_tab[slot] = src_tab[last];
            dest_tab[slot] = dest_tab[last];
            weight_tab[slot] = weight_tab[last];
            edge_count = last;
            want.status = elt_pkg::STAT_DELETED;
          end else begin
            want.status = elt_pkg::STAT_NOT_FOUND;
          end
        end
        default: want.status = (slot >= 0) ? elt_pkg::STAT_PRESENT : elt_pkg::STAT_NOT_FOUND;
      endcase
      want.count_after = elt_pkg::OUT_CNT_BITS'(edge_count);
      pending_results.push_back(want);
    endfunction

    task report(string what);
      err_count++;
      $display("ERROR: %s", what);
    endtask

    // Compare one accepted output transfer with the oldest prediction
    task check_result(elt_pkg::out_item_t got);
      elt_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.match_index !== want.match_index)
        report($sformatf("match_index got %0d want %0d", got.match_index, want.match_index));
      if (got.found !== want.found)
        report($sformatf("found got %0d want %0d", got.found, want.found));
      if (got.count_after !== want.count_after)
        report($sformatf("count_after got %0d want %0d", got.count_after, want.count_after));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  elt_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  elt_pkg::out_item_t out_data;

  edge_scoreboard sb;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  edge_list_table_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Hard stop if the run hangs
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Receiver stall, changed at the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Vertex ids: mostly a small pool so pairs repeat, plus top values and full range
  function automatic logic [elt_pkg::VERTEX_BITS-1:0] pick_vertex();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return elt_pkg::VERTEX_BITS'($urandom_range(0, 15));
    if (r < 70) begin
      return {elt_pkg::VERTEX_BITS{1'b1}} - elt_pkg::VERTEX_BITS'($urandom_range(0, 3));
    end
    return elt_pkg::VERTEX_BITS'($urandom);
  endfunction

  // Random operation; from_table takes the pair of a stored edge when there is one
  function automatic elt_pkg::in_item_t make_item(logic [elt_pkg::MODE_BITS-1:0] mode,
                                                  bit from_table);
    elt_pkg::in_item_t op;
    int unsigned idx;
    op.mode = mode;
    op.edge_weight = $urandom;
    if (from_table && sb.edge_count > 0) begin
      idx = $urandom_range(0, sb.edge_count - 1);
      op.src_vertex = sb.src_tab[idx];
      op.dest_vertex = sb.dest_tab[idx];
    end else begin
      op.src_vertex = pick_vertex();
      op.dest_vertex = pick_vertex();
    end
    return op;
  endfunction

  // One input transfer; idle gaps are decided before valid rises
  task automatic send_item(elt_pkg::in_item_t op);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op);
  endtask

  // Insert until the table is full, then push a few more at it
  task automatic fill_table();
    while (sb.edge_count < TABLE_DEPTH)
      send_item(make_item(elt_pkg::MODE_INSERT, $urandom_range(0, 9) == 0));
    repeat (4) send_item(make_item(elt_pkg::MODE_INSERT, $urandom_range(0, 1) == 1));
  endtask

  task automatic run_mixed(int unsigned n);
    logic [elt_pkg::MODE_BITS-1:0] mode;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: mode = elt_pkg::MODE_INSERT;
        1: mode = elt_pkg::MODE_DELETE;
        2: mode = elt_pkg::MODE_LOOKUP;
        default: mode = MODE_SPARE;
      endcase
      send_item(make_item(mode, $urandom_range(0, 1) == 1));
    end
  endtask

  // Mostly deletes of stored edges, some misses
  task automatic drain_table(int unsigned n);
    repeat (n) send_item(make_item(elt_pkg::MODE_DELETE, $urandom_range(0, 4) != 0));
  endtask

  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    fill_table();
    run_mixed(120);
    drain_table(60);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, extreme ids and weights, duplicates, spare code, moves
    send_item('{elt_pkg::MODE_LOOKUP, 16'h0000, 16'h0000, 32'sh0000_0000});
    send_item('{elt_pkg::MODE_DELETE, 16'h0000, 16'h0000, 32'sh0000_0000});
    send_item('{elt_pkg::MODE_INSERT, 16'h0000, 16'h0000, 32'sh8000_0000});
    send_item('{elt_pkg::MODE_INSERT, 16'hFFFF, 16'hFFFF, 32'sh7FFF_FFFF});
    send_item('{elt_pkg::MODE_INSERT, 16'h0000, 16'hFFFF, 32'sh0000_0000});
    send_item('{elt_pkg::MODE_INSERT, 16'hFFFF, 16'h0000, 32'shFFFF_FFFF});
    send_item('{elt_pkg::MODE_INSERT, 16'h0000, 16'h0000, 32'sh0000_0005});
    send_item('{elt_pkg::MODE_LOOKUP, 16'hFFFF, 16'hFFFF, 32'sh1234_5678});
    send_item('{MODE_SPARE,           16'h0000, 16'hFFFF, 32'sh0000_0000});
    send_item('{MODE_SPARE,           16'h0001, 16'h0001, 32'sh0000_0000});
    send_item('{elt_pkg::MODE_DELETE, 16'hFFFF, 16'hFFFF, 32'sh0000_0000});
    send_item('{elt_pkg::MODE_LOOKUP, 16'hFFFF, 16'h0000, 32'sh0000_0000});
    send_item('{elt_pkg::MODE_LOOKUP, 16'h0000, 16'hFFFF, 32'sh0000_0000});
    send_item('{elt_pkg::MODE_DELETE, 16'h0000, 16'hFFFF, 32'sh0000_0000});
    send_item('{elt_pkg::MODE_DELETE, 16'h0000, 16'hFFFF, 32'sh0000_0000});
    send_item('{elt_pkg::MODE_DELETE, 16'h0000, 16'h0000, 32'sh0000_0000});
    send_item('{elt_pkg::MODE_DELETE, 16'hFFFF, 16'h0000, 32'sh0000_0000});
    send_item('{elt_pkg::MODE_LOOKUP, 16'h0000, 16'h0000, 32'sh0000_0000});

    // Random: receiver-heavy stalls, sender-heavy gaps, then full rate
    run_phase(10, 66);
    run_phase(66, 10);
    run_phase(0, 0);

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== edge_list_table_core.f =====
design/elt_pkg.sv
design/elt_ctrl.sv
design/elt_dp.sv
design/edge_list_table_core.sv
tb/sv/edge_list_table_core_test.sv
